>>> sv/trex_pkg.sv
// Shared types, widths and constants for the triangle radial exit distance block.
// No dependencies; every other file imports this package.
package trex_pkg;

  localparam int COORD_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = 26;
  localparam int D3_W      = 27;
  localparam int POS_W     = 30;
  localparam int BOX_W     = 27;
  localparam int ANGLE_W   = 15;
  localparam int TRAVEL_W  = 24;
  localparam int RAD_W     = 25;
  localparam int Z_W       = 28;
  localparam int MUL_W     = 33;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;

  localparam int CORDIC_STEPS_DEF = 14;

  localparam logic signed [Z_W-1:0] PI_Q24    = 28'sd52707179;
  localparam logic signed [15:0]    ANGLE_MAX = 16'sd12868;
  localparam logic [MUL_W-1:0]      RECIP3    = 33'h0AAAAAAAB;
  localparam logic [TRAVEL_W-1:0]   TRAVEL_MAX = 24'hFFFFFF;

  localparam logic [COORD_W-1:0] TARGET_WIDTH_RST  = 24'd491520;
  localparam logic [COORD_W-1:0] TARGET_HEIGHT_RST = 24'd276480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_WIDTH   = 3'd0,
    REG_TARGET_HEIGHT  = 3'd1,
    REG_CENTER_LOCAL_X = 3'd2,
    REG_CENTER_LOCAL_Y = 3'd3,
    REG_CENTER_WORLD_X = 3'd4,
    REG_CENTER_WORLD_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TRI,
    KIND_CLEAR,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    last;
    logic signed [D3_W-1:0]  d3x;
    logic signed [D3_W-1:0]  d3y;
    logic [5:0][D3_W-1:0]    e;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [BOX_W-1:0]        boxx;
    logic [BOX_W-1:0]        boxy;
  } job_t;

  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/trex_isqrt.sv
// Shared integer square root, one result bit per cycle.
// Depends on trex_pkg.
module trex_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [trex_pkg::SQ_W-1:0]  value,
  output logic                       done,
  output logic [trex_pkg::ROOT_W-1:0] root
);
  import trex_pkg::*;

  logic            busy;
  logic [4:0]      step;
  logic [SQ_W-1:0] v, r, b, rb;

  assign rb   = r + b;
  assign root = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == 5'd31);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        v    <= value;
        r    <= '0;
        b    <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy) begin
        if (v >= rb) begin
          v <= v - rb;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b    <= b >> 2;
        step <= step + 5'd1;
        if (step == 5'd31) busy <= 1'b0;
      end
    end
  end

endmodule

>>> sv/trex_queue.sv
// Two-entry queue between the front and back parts.
// Depends on trex_pkg (job_t).
module trex_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  trex_pkg::job_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output trex_pkg::job_t  pop_data
);
  import trex_pkg::*;

  job_t       slot [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        slot[wp] <= push_data;
        wp       <= ~wp;
      end
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (!do_push && do_pop) count <= count - 2'd1;
    end
  end

endmodule

>>> sv/trex_front.sv
// Front part: accepts items, forms centroid offsets, vertex offsets and ray origin,
// classifies the item. Depends on trex_pkg.
module trex_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_a_x,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_a_y,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_b_x,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_b_y,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_c_x,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_c_y,
  input  logic                               last_of_batch,
  input  logic [trex_pkg::COORD_W-1:0]        target_width,
  input  logic [trex_pkg::COORD_W-1:0]        target_height,
  input  logic signed [trex_pkg::COORD_W-1:0] center_local_x,
  input  logic signed [trex_pkg::COORD_W-1:0] center_local_y,
  input  logic signed [trex_pkg::COORD_W-1:0] center_world_x,
  input  logic signed [trex_pkg::COORD_W-1:0] center_world_y,
  output logic                               job_valid,
  input  logic                               job_ready,
  output trex_pkg::job_t                     job
);
  import trex_pkg::*;

  function automatic logic signed [SUM_W-1:0] ext_c(input logic signed [COORD_W-1:0] v);
    return SUM_W'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] times3(input logic signed [COORD_W-1:0] v);
    return (ext_c(v) <<< 1) + ext_c(v);
  endfunction

  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [D3_W-1:0]   d3_x, d3_y;
  logic signed [POS_W-1:0]  org_x, org_y;
  job_t                     job_next;
  logic                     jv;

  always_comb begin
    sum_x = ext_c(vertex_a_x) + ext_c(vertex_b_x) + ext_c(vertex_c_x);
    sum_y = ext_c(vertex_a_y) + ext_c(vertex_b_y) + ext_c(vertex_c_y);
    d3_x  = D3_W'(sum_x) - D3_W'(times3(center_local_x));
    d3_y  = D3_W'(sum_y) - D3_W'(times3(center_local_y));
    org_x = POS_W'(times3(center_world_x)) + POS_W'(d3_x);
    org_y = POS_W'(times3(center_world_y)) + POS_W'(d3_y);

    job_next.last = last_of_batch;
    job_next.d3x  = d3_x;
    job_next.d3y  = d3_y;
    job_next.e[0] = D3_W'(times3(vertex_a_x)) - D3_W'(sum_x);
    job_next.e[1] = D3_W'(times3(vertex_a_y)) - D3_W'(sum_y);
    job_next.e[2] = D3_W'(times3(vertex_b_x)) - D3_W'(sum_x);
    job_next.e[3] = D3_W'(times3(vertex_b_y)) - D3_W'(sum_y);
    job_next.e[4] = D3_W'(times3(vertex_c_x)) - D3_W'(sum_x);
    job_next.e[5] = D3_W'(times3(vertex_c_y)) - D3_W'(sum_y);
    job_next.px   = org_x <<< 1;
    job_next.py   = org_y <<< 1;
    job_next.boxx = (BOX_W'(target_width) << 2) + (BOX_W'(target_width) << 1);
    job_next.boxy = (BOX_W'(target_height) << 2) + (BOX_W'(target_height) << 1);
    if (command) job_next.kind = KIND_CLEAR;
    else if (d3_x == '0 && d3_y == '0) job_next.kind = KIND_ZERO;
    else job_next.kind = KIND_TRI;
  end

  assign in_ready  = !jv || job_ready;
  assign job_valid = jv;

  always_ff @(posedge clk) begin
    if (rst) begin
      jv <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        jv  <= 1'b1;
        job <= job_next;
      end else if (job_ready) begin
        jv <= 1'b0;
      end
    end
  end

endmodule

>>> sv/trex_back.sv
// Back part: sequencer with one shared multiplier, square root unit, CORDIC,
// slab clip and restoring divider; holds the result register. Depends on trex_pkg.
module trex_back #(
  parameter int CORDIC_STEPS = trex_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  trex_pkg::job_t                      job,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [trex_pkg::ANGLE_W-1:0] angle,
  output logic [trex_pkg::TRAVEL_W-1:0]       triangle_travel,
  output logic [trex_pkg::TRAVEL_W-1:0]       max_travel,
  output logic                                direction_undefined,
  output logic                                batch_done
);
  import trex_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RSQ, S_RSTART, S_RSQRT, S_RDIV, S_RDIV2, S_CORDIC, S_CLIPX, S_CLIPY,
    S_LSQ, S_LSTART, S_LSQRT, S_LMUL, S_DCHK, S_DSAT, S_DIV, S_FIN
  } state_t;

  state_t                    state;
  job_t                      jb;
  logic [2:0]                cnt;
  logic [4:0]                ci;
  logic [SQ_W-1:0]           acc, best;
  logic [RAD_W-1:0]          radius;
  logic signed [63:0]        cx, cy;
  logic signed [Z_W-1:0]     cz;
  logic signed [ANGLE_W-1:0] ang;
  logic                      hit, tinf;
  logic signed [POS_W-1:0]   tmin_n, tmax_n;
  logic [D3_W-1:0]           tmin_d, tmax_d;
  logic signed [2*MUL_W-1:0] prod, hold;
  logic [ROOT_W-1:0]         lf;
  logic [63:0]               dn, dd, dsh;
  logic [TRAVEL_W-1:0]       quo, exit_dist, maxr;

  logic signed [MUL_W-1:0]   ma, mb;
  logic                      sq_start, sq_done;
  logic [SQ_W-1:0]           sq_val;
  logic [ROOT_W-1:0]         sq_root;

  logic signed [POS_W-1:0]   bxs, bys, n1x, n2x, n1y, n2y;
  logic [D3_W-1:0]           denx, deny;
  logic signed [63:0]        xs, ys, nx, ny;
  logic signed [Z_W-1:0]     nz, zr, at;
  logic signed [15:0]        a16;
  logic signed [ANGLE_W-1:0] ang_next;
  logic [SQ_W-1:0]           sq_sum;
  logic [TRAVEL_W+1:0]       tsum;
  logic [TRAVEL_W-1:0]       travel;
  logic signed [POS_W-1:0]   num;
  logic                      fin_fire;

  trex_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign sq_start  = (state == S_RSTART) || (state == S_LSTART);
  assign sq_val    = (state == S_RSTART) ? best : (acc << 8);
  assign job_ready = (state == S_IDLE);
  assign fin_fire  = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    bxs  = $signed(POS_W'(jb.boxx));
    bys  = $signed(POS_W'(jb.boxy));
    denx = jb.d3x[D3_W-1] ? D3_W'(-jb.d3x) : D3_W'(jb.d3x);
    deny = jb.d3y[D3_W-1] ? D3_W'(-jb.d3y) : D3_W'(jb.d3y);
    if (jb.d3x > 0) begin
      n1x = -jb.px;
      n2x = bxs - jb.px;
    end else begin
      n1x = jb.px - bxs;
      n2x = jb.px;
    end
    if (jb.d3y > 0) begin
      n1y = -jb.py;
      n2y = bys - jb.py;
    end else begin
      n1y = jb.py - bys;
      n2y = jb.py;
    end
    num = (tmax_n > 0) ? tmax_n : '0;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_RSQ: begin
        case (cnt)
          3'd0: ma = MUL_W'($signed(jb.e[0]));
          3'd1: ma = MUL_W'($signed(jb.e[1]));
          3'd2: ma = MUL_W'($signed(jb.e[2]));
          3'd3: ma = MUL_W'($signed(jb.e[3]));
          3'd4: ma = MUL_W'($signed(jb.e[4]));
          3'd5: ma = MUL_W'($signed(jb.e[5]));
          default: ma = '0;
        endcase
        mb = ma;
      end
      S_RDIV: begin
        ma = $signed(MUL_W'(sq_root) + MUL_W'(1));
        mb = $signed(RECIP3);
      end
      S_CLIPY: begin
        case (cnt)
          3'd0: begin ma = MUL_W'(tmin_n); mb = $signed(MUL_W'(deny));   end
          3'd1: begin ma = MUL_W'(n2y);    mb = $signed(MUL_W'(tmin_d)); end
          3'd2: begin ma = MUL_W'(tmax_n); mb = $signed(MUL_W'(deny));   end
          3'd3: begin ma = MUL_W'(n1y);    mb = $signed(MUL_W'(tmax_d)); end
          3'd4: begin ma = MUL_W'(n2y);    mb = $signed(MUL_W'(tmax_d)); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      S_LSQ: begin
        ma = (cnt == 3'd0) ? MUL_W'(jb.d3x) : MUL_W'(jb.d3y);
        mb = ma;
      end
      S_LMUL: begin
        ma = MUL_W'(num);
        mb = $signed(MUL_W'(lf));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    xs = cx >>> ci;
    ys = cy >>> ci;
    at = $signed(Z_W'(atan_entry(ci)));
    if (cy >= 0) begin
      nx = cx + ys;
      ny = cy - xs;
      nz = cz + at;
    end else begin
      nx = cx - ys;
      ny = cy + xs;
      nz = cz - at;
    end
    zr  = cz + Z_W'(2048);
    a16 = 16'(zr >>> 12);
    if (a16 > ANGLE_MAX) a16 = ANGLE_MAX;
    else if (a16 < -ANGLE_MAX) a16 = -ANGLE_MAX;
    ang_next = ANGLE_W'(a16);
    sq_sum   = acc + prod[SQ_W-1:0];
    tsum     = {2'b00, exit_dist} + {1'b0, radius};
    if (!hit) travel = '0;
    else if (tsum > {2'b00, TRAVEL_MAX}) travel = TRAVEL_MAX;
    else travel = tsum[TRAVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      maxr      <= '0;
      cnt       <= '0;
      ci        <= '0;
    end else begin
      prod <= ma * mb;
      if (fin_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            jb        <= job;
            cnt       <= '0;
            best      <= '0;
            hit       <= 1'b1;
            exit_dist <= '0;
            state     <= (job.kind == KIND_TRI) ? S_RSQ : S_FIN;
          end
        end
        S_RSQ: begin
          if (cnt != 3'd0) begin
            if (cnt[0]) acc <= prod[SQ_W-1:0];
            else if (sq_sum > best) best <= sq_sum;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) state <= S_RSTART;
        end
        S_RSTART: state <= S_RSQRT;
        S_RSQRT: if (sq_done) state <= S_RDIV;
        S_RDIV: state <= S_RDIV2;
        S_RDIV2: begin
          radius <= prod[RAD_W+32:33];
          ci     <= '0;
          if (jb.d3y < 0) begin
            cx <= -($signed(64'(jb.d3y)) <<< 32);
            cy <= -($signed(64'(jb.d3x)) <<< 32);
            cz <= (jb.d3x >= 0) ? PI_Q24 : -PI_Q24;
          end else begin
            cx <= $signed(64'(jb.d3y)) <<< 32;
            cy <= $signed(64'(jb.d3x)) <<< 32;
            cz <= '0;
          end
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (ci == 5'(CORDIC_STEPS)) begin
            ang   <= ang_next;
            state <= S_CLIPX;
          end else begin
            cx <= nx;
            cy <= ny;
            cz <= nz;
            ci <= ci + 5'd1;
          end
        end
        S_CLIPX: begin
          cnt <= '0;
          if (jb.d3x == '0) begin
            tinf   <= 1'b1;
            tmin_n <= '0;
            tmin_d <= D3_W'(1);
            tmax_n <= '0;
            tmax_d <= D3_W'(1);
            hit    <= (jb.px >= 0) && (jb.px <= bxs);
            state  <= ((jb.px >= 0) && (jb.px <= bxs)) ? S_CLIPY : S_FIN;
          end else begin
            tinf   <= 1'b0;
            tmax_n <= n2x;
            tmax_d <= denx;
            if (n1x > 0) begin
              tmin_n <= n1x;
              tmin_d <= denx;
            end else begin
              tmin_n <= '0;
              tmin_d <= D3_W'(1);
            end
            hit   <= (n2x >= 0);
            state <= (n2x >= 0) ? S_CLIPY : S_FIN;
          end
        end
        S_CLIPY: begin
          if (jb.d3y == '0) begin
            cnt   <= '0;
            hit   <= (jb.py >= 0) && (jb.py <= bys);
            state <= ((jb.py >= 0) && (jb.py <= bys)) ? S_LSQ : S_FIN;
          end else begin
            cnt <= (cnt == 3'd5) ? 3'd0 : cnt + 3'd1;
            case (cnt)
              3'd1: hold <= prod;
              3'd2: if (prod < hold) hit <= 1'b0;
              3'd3: hold <= prod;
              3'd4: if (!tinf && prod > hold) hit <= 1'b0;
              3'd5: begin
                if (tinf || prod < hold) begin
                  tmax_n <= n2y;
                  tmax_d <= deny;
                  tinf   <= 1'b0;
                end
                state <= hit ? S_LSQ : S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_LSQ: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) acc <= prod[SQ_W-1:0];
          if (cnt == 3'd2) begin
            acc   <= sq_sum;
            state <= S_LSTART;
          end
        end
        S_LSTART: state <= S_LSQRT;
        S_LSQRT: begin
          if (sq_done) begin
            lf    <= sq_root;
            state <= S_LMUL;
          end
        end
        S_LMUL: state <= S_DCHK;
        S_DCHK: begin
          dn    <= prod[63:0] + (64'(tmax_d) << 5) + (64'(tmax_d) << 4);
          dd    <= (64'(tmax_d) << 6) + (64'(tmax_d) << 5);
          state <= S_DSAT;
        end
        S_DSAT: begin
          ci  <= '0;
          quo <= '0;
          dsh <= dd << 23;
          if (dn >= (dd << 24)) begin
            exit_dist <= TRAVEL_MAX;
            state     <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dn >= dsh) begin
            dn  <= dn - dsh;
            quo <= {quo[TRAVEL_W-2:0], 1'b1};
          end else begin
            quo <= {quo[TRAVEL_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          ci  <= ci + 5'd1;
          if (ci == 5'd24) begin
            exit_dist <= quo;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            batch_done <= jb.last;
            case (jb.kind)
              KIND_CLEAR: begin
                angle               <= '0;
                triangle_travel     <= '0;
                max_travel          <= '0;
                direction_undefined <= 1'b0;
                maxr                <= '0;
              end
              KIND_ZERO: begin
                angle               <= '0;
                triangle_travel     <= '0;
                max_travel          <= maxr;
                direction_undefined <= 1'b1;
              end
              default: begin
                angle               <= ang;
                triangle_travel     <= travel;
                direction_undefined <= 1'b0;
                if (travel > maxr) begin
                  maxr       <= travel;
                  max_travel <= travel;
                end else begin
                  max_travel <= maxr;
                end
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_max_covers_travel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_travel >= triangle_travel)
    else $error("max_travel below triangle_travel");

  a_undef_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && direction_undefined |-> triangle_travel == '0 && angle == '0)
    else $error("undefined direction with nonzero result");

  a_root_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_RSQRT || state == S_LSQRT))
    else $error("square root finished outside a wait state");

  a_max_nondecreasing: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && jb.kind != KIND_CLEAR |=> maxr >= $past(maxr))
    else $error("running maximum decreased");
`endif

endmodule

>>> sv/triangle_radial_exit_distance.sv
// Top level: configuration registers, front part, queue and back part.
// Depends on trex_pkg, trex_front, trex_queue, trex_back.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//  input    | in_valid/in_ready, command..last_of_batch| in
//  result   | out_valid/out_ready, angle..batch_done   | out
//
// For a triangle, the back part makes two passes through the shared square-root
// unit and then runs the restoring divider. Clear and zero-offset items go from
// idle straight to the result state. Reset is synchronous; the running maximum
// and registers return to their reset values. Until they are full, the front
// and the 2-entry queue accept items while the back part works or output stalls.
module triangle_radial_exit_distance #(
  parameter int CORDIC_STEPS = trex_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trex_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trex_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_a_x,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_a_y,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_b_x,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_b_y,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_c_x,
  input  logic signed [trex_pkg::COORD_W-1:0] vertex_c_y,
  input  logic                                last_of_batch,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [trex_pkg::ANGLE_W-1:0] angle,
  output logic [trex_pkg::TRAVEL_W-1:0]       triangle_travel,
  output logic [trex_pkg::TRAVEL_W-1:0]       max_travel,
  output logic                                direction_undefined,
  output logic                                batch_done
);
  import trex_pkg::*;

  logic [COORD_W-1:0]        target_width, target_height;
  logic signed [COORD_W-1:0] center_local_x, center_local_y;
  logic signed [COORD_W-1:0] center_world_x, center_world_y;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_width   <= TARGET_WIDTH_RST;
      target_height  <= TARGET_HEIGHT_RST;
      center_local_x <= '0;
      center_local_y <= '0;
      center_world_x <= '0;
      center_world_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_WIDTH:   target_width   <= cfg_data;
        REG_TARGET_HEIGHT:  target_height  <= cfg_data;
        REG_CENTER_LOCAL_X: center_local_x <= cfg_data;
        REG_CENTER_LOCAL_Y: center_local_y <= cfg_data;
        REG_CENTER_WORLD_X: center_world_x <= cfg_data;
        REG_CENTER_WORLD_Y: center_world_y <= cfg_data;
        default: ;
      endcase
    end
  end

  trex_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .vertex_a_x     (vertex_a_x),
    .vertex_a_y     (vertex_a_y),
    .vertex_b_x     (vertex_b_x),
    .vertex_b_y     (vertex_b_y),
    .vertex_c_x     (vertex_c_x),
    .vertex_c_y     (vertex_c_y),
    .last_of_batch  (last_of_batch),
    .target_width   (target_width),
    .target_height  (target_height),
    .center_local_x (center_local_x),
    .center_local_y (center_local_y),
    .center_world_x (center_world_x),
    .center_world_y (center_world_y),
    .job_valid      (fq_valid),
    .job_ready      (fq_ready),
    .job            (fq_job)
  );

  trex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  trex_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .job_valid           (qb_valid),
    .job_ready           (qb_ready),
    .job                 (qb_job),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .angle               (angle),
    .triangle_travel     (triangle_travel),
    .max_travel          (max_travel),
    .direction_undefined (direction_undefined),
    .batch_done          (batch_done)
  );

endmodule

>>> verif/triangle_radial_exit_distance_tb.sv
// Testbench for triangle_radial_exit_distance: directed and random triangles,
// register phases, random idling and a long output stall. Depends on trex_pkg and triangle_radial_exit_distance.
module triangle_radial_exit_distance_tb;
  import trex_pkg::*;

  typedef struct {
    logic        command;
    logic [23:0] ax, ay, bx, by, cx, cy;
    logic        last;
  } tri_item_t;

  typedef struct {
    logic [14:0] angle;
    logic [23:0] travel;
    logic [23:0] max_travel;
    logic        undef;
    logic        done;
  } tri_result_t;

  localparam longint PRESCALE_F = 64'sd4294967296;
  localparam int     LIMIT = 20000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic command, last_of_batch;
  logic signed [COORD_W-1:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
  logic signed [COORD_W-1:0] vertex_c_x, vertex_c_y;
  logic out_valid, out_ready;
  logic signed [ANGLE_W-1:0] angle;
  logic [TRAVEL_W-1:0] triangle_travel, max_travel;
  logic direction_undefined, batch_done;

  triangle_radial_exit_distance u_dut (.*);

  // predictor state
  longint tw, th, clx, cly, cwx, cwy;
  longint run_max = 0;

  tri_item_t   pending_items[$];
  tri_result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles;
  int hold_off;
  bit stall_go, stall_used;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint sx(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_angle(longint yc, longint xc);
    longint x, y, z, a, nx, ny;
    x = xc * PRESCALE_F;
    y = yc * PRESCALE_F;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i); ny = y - shr(x, i); z += longint'(atan_entry(5'(i)));
      end else begin
        nx = x - shr(y, i); ny = y + shr(x, i); z -= longint'(atan_entry(5'(i)));
      end
      x = nx; y = ny;
    end
    a = shr(z + 2048, 12);
    if (a > 12868) a = 12868;
    if (a < -12868) a = -12868;
    return a;
  endfunction

  function automatic bit clip_slab(longint p, longint box, longint v,
                                   inout longint mn_n, inout longint mn_d,
                                   inout bit mx_inf, inout longint mx_n,
                                   inout longint mx_d);
    longint n1, n2, den, t;
    if (v == 0) return !(p < 0 || p > box);
    if (v > 0) begin
      n1 = -p; n2 = box - p; den = v;
    end else begin
      n1 = p - box; n2 = p; den = -v;
    end
    if (n1 > n2) begin
      t = n1; n1 = n2; n2 = t;
    end
    if (n2 * mn_d < mn_n * den) return 0;
    if (!mx_inf && n1 * mx_d > mx_n * den) return 0;
    if (n1 * mn_d > mn_n * den) begin
      mn_n = n1; mn_d = den;
    end
    if (mx_inf || n2 * mx_d < mx_n * den) begin
      mx_n = n2; mx_d = den; mx_inf = 0;
    end
    return 1;
  endfunction

  function automatic tri_result_t predict_exit(tri_item_t it);
    tri_result_t r;
    longint sumx, sumy, d3x, d3y, px, py, e[6];
    longint mn_n, mn_d, mx_n, mx_d;
    longint unsigned best, sq, radius, travel, num, den, lf, exit_dist;
    bit mx_inf, hit;
    r = '{15'd0, 24'd0, 24'd0, 1'b0, it.last};
    if (it.command) begin
      run_max = 0;
      return r;
    end
    sumx = sx(it.ax) + sx(it.bx) + sx(it.cx);
    sumy = sx(it.ay) + sx(it.by) + sx(it.cy);
    d3x = sumx - 3 * clx;
    d3y = sumy - 3 * cly;
    if (d3x == 0 && d3y == 0) begin
      r.max_travel = run_max[23:0];
      r.undef = 1'b1;
      return r;
    end
    r.angle = 15'(cordic_angle(d3x, d3y));
    e[0] = 3 * sx(it.ax) - sumx; e[1] = 3 * sx(it.ay) - sumy;
    e[2] = 3 * sx(it.bx) - sumx; e[3] = 3 * sx(it.by) - sumy;
    e[4] = 3 * sx(it.cx) - sumx; e[5] = 3 * sx(it.cy) - sumy;
    best = 0;
    for (int k = 0; k < 3; k++) begin
      sq = longint'(e[2*k] * e[2*k]) + longint'(e[2*k+1] * e[2*k+1]);
      if (sq > best) best = sq;
    end
    radius = (root64(best) + 1) / 3;
    px = 2 * (3 * cwx + d3x);
    py = 2 * (3 * cwy + d3y);
    mn_n = 0; mn_d = 1; mx_n = 0; mx_d = 1; mx_inf = 1;
    travel = 0;
    hit = clip_slab(px, 6 * tw, d3x, mn_n, mn_d, mx_inf, mx_n, mx_d);
    if (hit) hit = clip_slab(py, 6 * th, d3y, mn_n, mn_d, mx_inf, mx_n, mx_d);
    if (hit && !mx_inf) begin
      num = mx_n > 0 ? mx_n : 0;
      den = mx_d;
      sq = longint'(d3x * d3x) + longint'(d3y * d3y);
      lf = root64(sq << 8);
      exit_dist = (num * lf + den * 48) / (den * 96);
      if (exit_dist > 64'hFFFFFF) exit_dist = 64'hFFFFFF;
      travel = exit_dist + radius;
      if (travel > 64'hFFFFFF) travel = 64'hFFFFFF;
    end
    if (travel > run_max) run_max = travel;
    r.travel = travel[23:0];
    r.max_travel = run_max[23:0];
    return r;
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      command <= 1'b0;
      last_of_batch <= 1'b0;
      vertex_a_x <= '0; vertex_a_y <= '0; vertex_b_x <= '0;
      vertex_b_y <= '0; vertex_c_x <= '0; vertex_c_y <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_exit(pending_items.pop_front()));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          command <= pending_items[0].command;
          vertex_a_x <= pending_items[0].ax; vertex_a_y <= pending_items[0].ay;
          vertex_b_x <= pending_items[0].bx; vertex_b_y <= pending_items[0].by;
          vertex_c_x <= pending_items[0].cx; vertex_c_y <= pending_items[0].cy;
          last_of_batch <= pending_items[0].last;
          in_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
        end else in_valid <= 1'b0;
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
      stall_used <= 1'b0;
    end else if (stall_go && !stall_used) begin
      hold_off <= 400;
      stall_used <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  int out_gap;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $time);
        end else begin
          tri_result_t x;
          x = expected_results.pop_front();
          if (x.angle !== angle || x.travel !== triangle_travel ||
              x.max_travel !== max_travel || x.undef !== direction_undefined ||
              x.done !== batch_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %b %b got %h %h %h %b %b",
                       x.angle, x.travel, x.max_travel, x.undef, x.done, angle,
                       triangle_travel, max_travel, direction_undefined, batch_done);
          end
        end
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready)
          out_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
      idle_cycles <= 0;
    else if (pending_items.size() != 0 || expected_results.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_WIDTH:   tw = val;
      REG_TARGET_HEIGHT:  th = val;
      REG_CENTER_LOCAL_X: clx = sx(val);
      REG_CENTER_LOCAL_Y: cly = sx(val);
      REG_CENTER_WORLD_X: cwx = sx(val);
      default:            cwy = sx(val);
    endcase
  endtask

  task automatic drain_queue();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_tri(logic c, logic [23:0] ax, ay, bx, by, cx, cy, logic l);
    tri_item_t it;
    it = '{c, ax, ay, bx, by, cx, cy, l};
    pending_items.push_back(it);
  endtask

  function automatic logic [23:0] near_coord(int span);
    return 24'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic add_random(int n);
    logic [23:0] bx, by, sp;
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 19);
      if (mode == 0)
        add_tri(1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom), 24'($urandom), 1'($urandom));
      else if (mode < 3)
        add_tri(1'b0, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom), 24'($urandom), 1'($urandom));
      else begin
        bx = 24'(clx) + near_coord(200000);
        by = 24'(cly) + near_coord(200000);
        sp = $urandom_range(0, 3) == 0 ? 24'd40000 : 24'd3000;
        add_tri(1'b0, bx + near_coord(int'(sp)), by + near_coord(int'(sp)),
                bx + near_coord(int'(sp)), by + near_coord(int'(sp)),
                bx + near_coord(int'(sp)), by + near_coord(int'(sp)),
                $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    stall_go = 1'b0;
    tw = 491520; th = 276480; clx = 0; cly = 0; cwx = 0; cwy = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, clear, zero offset, parallel axes, saturation
    add_tri(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
            24'h7FFFFF, 1'b0);
    add_tri(1'b0, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
            24'h800000, 1'b1);
    add_tri(1'b0, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h000000,
            24'h000000, 1'b0);
    add_tri(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    add_tri(1'b0, 24'd3, -24'sd3, -24'sd3, 24'd3, 24'd0, 24'd0, 1'b0);
    add_tri(1'b0, 24'd300, 24'd0, 24'd300, 24'd0, 24'd300, 24'd0, 1'b0);
    add_tri(1'b0, 24'd0, 24'd300, 24'd0, 24'd300, 24'd0, 24'd300, 1'b0);
    add_tri(1'b0, -24'sd300, 24'd0, -24'sd300, 24'd0, -24'sd300, 24'd0, 1'b0);
    add_tri(1'b0, 24'd0, -24'sd300, 24'd0, -24'sd300, 24'd0, -24'sd300, 1'b0);
    add_tri(1'b0, -24'sd5, -24'sd7, -24'sd5, -24'sd7, -24'sd5, -24'sd7, 1'b0);
    add_tri(1'b0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
    add_tri(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
            24'h800000, 1'b0);
    add_tri(1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
            24'h800000, 1'b1);
    add_tri(1'b0, 24'd5000, 24'd100, 24'd5100, 24'd200, 24'd4900, 24'd0, 1'b0);
    drain_queue();

    // long receiver stall while the sender keeps offering
    stall_go = 1'b1;
    add_random(20);
    drain_queue();

    write_reg(REG_TARGET_WIDTH, 24'hFFFFFF);
    write_reg(REG_TARGET_HEIGHT, 24'hFFFFFF);
    write_reg(REG_CENTER_LOCAL_X, 24'h7FFFFF);
    write_reg(REG_CENTER_LOCAL_Y, 24'h800000);
    write_reg(REG_CENTER_WORLD_X, 24'h800000);
    write_reg(REG_CENTER_WORLD_Y, 24'h7FFFFF);
    add_tri(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
            24'h800000, 1'b0);
    add_random(300);
    drain_queue();

    write_reg(REG_TARGET_WIDTH, 24'd0);
    write_reg(REG_TARGET_HEIGHT, 24'd0);
    write_reg(REG_CENTER_WORLD_X, 24'd0);
    write_reg(REG_CENTER_WORLD_Y, 24'd0);
    add_random(200);
    drain_queue();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_TARGET_WIDTH, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_TARGET_HEIGHT, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_CENTER_LOCAL_X, 24'($urandom));
      write_reg(REG_CENTER_LOCAL_Y, 24'($urandom));
      write_reg(REG_CENTER_WORLD_X,
                (ph % 2) ? 24'($urandom) : 24'($urandom_range(0, 24'h1FFFFF)));
      write_reg(REG_CENTER_WORLD_Y,
                (ph % 2) ? 24'($urandom) : 24'($urandom_range(0, 24'h1FFFFF)));
      add_random(230);
      drain_queue();
    end

    $display("ran %0d items, %0d results, over 9 register settings", items_sent,
             results_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
